// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge of clk, skipped while rst is high.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check an implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/smrr_pkg.sv =====
`timescale 1ns / 1ps

package smrr_pkg;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_TOKEN  = 3'd1,
      PH_DATA   = 3'd2,
      PH_CRC_HI = 3'd3,
      PH_CRC_LO = 3'd4,
      PH_DONE   = 3'd5,
      PH_HALT   = 3'd6
   } phase_type;

   typedef enum logic {
      REQ_BYTE  = 1'b0,
      REQ_START = 1'b1
   } req_kind_type;

   localparam logic [7:0]  DATA_TOKEN = 8'hFE;
   localparam logic [15:0] CRC_POLY   = 16'h1021;

endpackage

// ===== rtl/core/smrr_crc16.sv =====
`timescale 1ns / 1ps

module smrr_crc16 (
   input  logic [15:0] crc_in,
   input  logic [7:0]  data_in,
   output logic [15:0] crc_out
);
   import smrr_pkg::*;

   always_comb begin
      logic [15:0] crc;
      crc = crc_in ^ {data_in, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (crc[15]) begin
            crc = {crc[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            crc = {crc[14:0], 1'b0};
         end
      end
      crc_out = crc;
   end

endmodule

// ===== rtl/core/sd_multiblock_read_receiver.sv =====
// A result is registered and appears in the cycle after its request transfer.
// Throughput: one request per cycle unless stalled; the bytewise CRC-16 update
// and the block counter compare sit between request port and result register.
// Reset (synchronous, active high) returns the receiver to idle with a block
// count of zero, clears all counters and the error flag, and empties the result.
`timescale 1ns / 1ps

module sd_multiblock_read_receiver #(
   parameter int BLOCK_BYTES = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_payload_valid,
   output logic [7:0]  rsp_payload_byte,
   output logic [8:0]  rsp_byte_offset,
   output logic [31:0] rsp_block_number,
   output logic        rsp_block_checked,
   output logic        rsp_crc_error,
   output logic        rsp_transfer_done,
   output logic        rsp_busy_res,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);
   import smrr_pkg::*;

   localparam int CNT_W = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
   localparam logic [CNT_W-1:0] LAST_BYTE = CNT_W'(BLOCK_BYTES - 1);

   logic [31:0]      blocks_to_read_ff;
   phase_type        phase_ff, phase_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [15:0]      crc_ff, crc_in;
   logic [7:0]       crc_high_ff, crc_high_in;
   logic [31:0]      blocks_done_ff, blocks_done_in;
   logic             error_ff, error_in;

   logic             rsp_valid_ff;
   logic             pay_valid_ff, pay_valid_in;
   logic [7:0]       pay_byte_ff, pay_byte_in;
   logic [8:0]       offset_ff, offset_in;
   logic [31:0]      block_num_ff, block_num_in;
   logic             checked_ff, checked_in;

   logic             accept;
   logic [15:0]      crc_next;
   logic [CNT_W+8:0] count_ext;
   logic [32:0]      blocks_next;

   smrr_crc16 u_crc (
      .crc_in  (crc_ff),
      .data_in (req_rx_byte),
      .crc_out (crc_next)
   );

   assign req_stall   = rsp_valid_ff & rsp_stall;
   assign accept      = req_valid & ~req_stall;
   assign count_ext   = {9'd0, count_ff};
   assign blocks_next = {1'b0, blocks_done_ff} + 33'd1;

   always_comb begin
      phase_in       = phase_ff;
      count_in       = count_ff;
      crc_in         = crc_ff;
      crc_high_in    = crc_high_ff;
      blocks_done_in = blocks_done_ff;
      error_in       = error_ff;
      pay_valid_in   = 1'b0;
      pay_byte_in    = 8'd0;
      offset_in      = 9'd0;
      block_num_in   = blocks_done_ff;
      checked_in     = 1'b0;
      if (req_type == REQ_START) begin
         blocks_done_in = 32'd0;
         block_num_in   = 32'd0;
         count_in       = '0;
         crc_in         = 16'd0;
         crc_high_in    = 8'd0;
         error_in       = 1'b0;
         phase_in       = (blocks_to_read_ff == 32'd0) ? PH_DONE : PH_TOKEN;
      end else begin
         case (phase_ff)
            PH_TOKEN: begin
               if (req_rx_byte == DATA_TOKEN) begin
                  phase_in = PH_DATA;
                  count_in = '0;
                  crc_in   = 16'd0;
               end
            end
            PH_DATA: begin
               pay_valid_in = 1'b1;
               pay_byte_in  = req_rx_byte;
               offset_in    = count_ext[8:0];
               crc_in       = crc_next;
               if (count_ff == LAST_BYTE) begin
                  phase_in = PH_CRC_HI;
                  count_in = '0;
               end else begin
                  count_in = count_ff + CNT_W'(1);
               end
            end
            PH_CRC_HI: begin
               crc_high_in = req_rx_byte;
               phase_in    = PH_CRC_LO;
            end
            PH_CRC_LO: begin
               checked_in = 1'b1;
               if ({crc_high_ff, req_rx_byte} != crc_ff) begin
                  error_in = 1'b1;
                  phase_in = PH_HALT;
               end else begin
                  blocks_done_in = blocks_next[31:0];
                  phase_in = (blocks_next >= {1'b0, blocks_to_read_ff}) ? PH_DONE : PH_TOKEN;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blocks_to_read_ff <= 32'd0;
         phase_ff          <= PH_IDLE;
         count_ff          <= '0;
         crc_ff            <= 16'd0;
         crc_high_ff       <= 8'd0;
         blocks_done_ff    <= 32'd0;
         error_ff          <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            blocks_to_read_ff <= csr_wr_data;
         end
         if (accept) begin
            phase_ff       <= phase_in;
            count_ff       <= count_in;
            crc_ff         <= crc_in;
            crc_high_ff    <= crc_high_in;
            blocks_done_ff <= blocks_done_in;
            error_ff       <= error_in;
            rsp_valid_ff   <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff   <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pay_valid_ff <= pay_valid_in;
         pay_byte_ff  <= pay_byte_in;
         offset_ff    <= offset_in;
         block_num_ff <= block_num_in;
         checked_ff   <= checked_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_payload_valid = pay_valid_ff;
   assign rsp_payload_byte  = pay_byte_ff;
   assign rsp_byte_offset   = offset_ff;
   assign rsp_block_number  = block_num_ff;
   assign rsp_block_checked = checked_ff;
   assign rsp_crc_error     = error_ff;
   assign rsp_transfer_done = (phase_ff == PH_DONE);
   assign rsp_busy_res      = phase_ff inside {PH_TOKEN, PH_DATA, PH_CRC_HI, PH_CRC_LO};

`include "assert_macros.svh"

   `ASSERT_NEXT(a_accept_gives_rsp, clock, reset, accept, rsp_valid_ff, "transfer lost")
   `ASSERT_CLK(a_done_not_busy, clock, reset, !(rsp_transfer_done && rsp_busy_res), "done while busy")
   `ASSERT_CLK(a_payload_busy, clock, reset, !(rsp_valid_ff && rsp_payload_valid) || (rsp_busy_res && !rsp_crc_error), "payload outside transfer")
   `ASSERT_CLK(a_error_halts, clock, reset, !rsp_crc_error || (phase_ff == PH_HALT), "error without halt")

endmodule
